### hw/rtl/rau_pkg.sv
package rau_pkg;

  localparam int OPERAND_WIDTH = 32;
  localparam int IN_W = 32;
  localparam int PROD_W = 2 * OPERAND_WIDTH;
  localparam int DW = 64;
  localparam int WHOLE_W = 64;
  localparam int FRAC_W = 63;
  localparam int SHIFT_W = 7;
  localparam int CNT_W = 6;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW = 1;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_RED = 3'd4;

  typedef struct packed {
    logic          num_neg;
    logic [DW-1:0] num_mag;
    logic          den_neg;
    logic [DW-1:0] den_mag;
  } rau_item_t;

  function automatic logic [OPERAND_WIDTH-1:0] mag_of(logic [OPERAND_WIDTH-1:0] v);
    mag_of = v[OPERAND_WIDTH-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

### hw/rtl/rau_front.sv
module rau_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  logic [2:0]                      in_opcode,
  input  logic signed [rau_pkg::IN_W-1:0] in_first_numerator,
  input  logic signed [rau_pkg::IN_W-1:0] in_first_denominator,
  input  logic signed [rau_pkg::IN_W-1:0] in_second_numerator,
  input  logic signed [rau_pkg::IN_W-1:0] in_second_denominator,
  output logic                            q_push,
  input  logic                            q_full,
  output rau_pkg::rau_item_t              q_item
);

  localparam int W = rau_pkg::OPERAND_WIDTH;
  localparam int PW = rau_pkg::PROD_W;

  typedef enum logic [5:0] {
    F_IDLE = 6'b000001,
    F_MUL0 = 6'b000010,
    F_MUL1 = 6'b000100,
    F_MUL2 = 6'b001000,
    F_ADD  = 6'b010000,
    F_PUSH = 6'b100000
  } front_state_t;

  front_state_t state_r, state_nxt;
  logic [2:0]   op_r;
  logic [W-1:0] n1_r, d1_r, n2_r, d2_r;
  logic         n1s_r, d1s_r, n2s_r, d2s_r;
  logic [PW-1:0] num_r, num_nxt, den_r, den_nxt, y_r, y_nxt;
  logic         nums_r, nums_nxt, dens_r, dens_nxt, ys_r, ys_nxt;
  logic [W-1:0] ma, mb;
  logic         sa, sb;
  logic [PW-1:0] prod;
  logic         prod_neg;
  logic [PW-1:0] sum_mag;
  logic         sum_neg;
  logic         accept;

  assign accept = push && !full;
  assign full = (state_r != F_IDLE);

  always_comb begin
    ma = d1_r;
    mb = d2_r;
    sa = d1s_r;
    sb = d2s_r;
    case (state_r)
      F_MUL0: begin
        if (op_r == rau_pkg::OP_DIV) begin
          ma = n2_r; sa = n2s_r; mb = d1_r; sb = d1s_r;
        end
      end
      F_MUL1: begin
        ma = n1_r; sa = n1s_r;
        if (op_r == rau_pkg::OP_MUL) begin
          mb = n2_r; sb = n2s_r;
        end
      end
      F_MUL2: begin
        ma = n2_r; sa = n2s_r; mb = d1_r; sb = d1s_r;
      end
      default: begin
      end
    endcase
  end

  assign prod = PW'(ma) * PW'(mb);
  assign prod_neg = (prod != '0) && (sa != sb);

  always_comb begin
    if (nums_r == ys_r) begin
      sum_mag = num_r + y_r;
      sum_neg = nums_r;
    end else if (num_r >= y_r) begin
      sum_mag = num_r - y_r;
      sum_neg = nums_r;
    end else begin
      sum_mag = y_r - num_r;
      sum_neg = ys_r;
    end
    if (sum_mag == '0) sum_neg = 1'b0;
  end

  always_comb begin
    state_nxt = state_r;
    num_nxt = num_r;
    nums_nxt = nums_r;
    den_nxt = den_r;
    dens_nxt = dens_r;
    y_nxt = y_r;
    ys_nxt = ys_r;
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          if (in_opcode inside {rau_pkg::OP_ADD, rau_pkg::OP_SUB, rau_pkg::OP_MUL,
                                rau_pkg::OP_DIV}) begin
            state_nxt = F_MUL0;
          end else begin
            state_nxt = F_PUSH;
            num_nxt = PW'(rau_pkg::mag_of(in_first_numerator[W-1:0]));
            nums_nxt = in_first_numerator[W-1];
            den_nxt = PW'(rau_pkg::mag_of(in_first_denominator[W-1:0]));
            dens_nxt = in_first_denominator[W-1];
          end
        end
      end
      F_MUL0: begin
        den_nxt = prod;
        dens_nxt = prod_neg;
        state_nxt = F_MUL1;
      end
      F_MUL1: begin
        num_nxt = prod;
        nums_nxt = prod_neg;
        state_nxt = (op_r inside {rau_pkg::OP_MUL, rau_pkg::OP_DIV}) ? F_PUSH : F_MUL2;
      end
      F_MUL2: begin
        y_nxt = prod;
        ys_nxt = (op_r == rau_pkg::OP_SUB) ? (prod != '0) && !prod_neg : prod_neg;
        state_nxt = F_ADD;
      end
      F_ADD: begin
        num_nxt = sum_mag;
        nums_nxt = sum_neg;
        state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (!q_full) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  assign q_push = (state_r == F_PUSH) && !q_full;
  assign q_item.num_neg = nums_r;
  assign q_item.num_mag = rau_pkg::DW'(num_r);
  assign q_item.den_neg = dens_r;
  assign q_item.den_mag = rau_pkg::DW'(den_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_opcode;
      n1_r <= rau_pkg::mag_of(in_first_numerator[W-1:0]);
      d1_r <= rau_pkg::mag_of(in_first_denominator[W-1:0]);
      n2_r <= rau_pkg::mag_of(in_second_numerator[W-1:0]);
      d2_r <= rau_pkg::mag_of(in_second_denominator[W-1:0]);
      n1s_r <= in_first_numerator[W-1];
      d1s_r <= in_first_denominator[W-1];
      n2s_r <= in_second_numerator[W-1];
      d2s_r <= in_second_denominator[W-1];
    end
    num_r <= num_nxt;
    nums_r <= nums_nxt;
    den_r <= den_nxt;
    dens_r <= dens_nxt;
    y_r <= y_nxt;
    ys_r <= ys_nxt;
  end

endmodule

### hw/rtl/rau_fifo.sv
module rau_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  rau_pkg::rau_item_t wr_data,
  output logic               fifo_full,
  input  logic               rd_en,
  output rau_pkg::rau_item_t rd_data,
  output logic               fifo_empty
);

  rau_pkg::rau_item_t mem_r [rau_pkg::FIFO_DEPTH];
  logic [rau_pkg::FIFO_AW-1:0] wp_r, rp_r;
  logic [rau_pkg::FIFO_AW:0]   cnt_r;

  assign fifo_full = (cnt_r == (rau_pkg::FIFO_AW+1)'(rau_pkg::FIFO_DEPTH));
  assign fifo_empty = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      if (wr_en && !rd_en) cnt_r <= cnt_r + 1'b1;
      else if (rd_en && !wr_en) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

endmodule

### hw/rtl/rau_back.sv
module rau_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  rau_pkg::rau_item_t            q_item,
  output logic                          q_pop,
  output logic                          empty,
  input  logic                          pop,
  output logic                          out_is_infinite,
  output logic                          out_is_negative,
  output logic [rau_pkg::WHOLE_W-1:0]   out_whole_part,
  output logic [rau_pkg::FRAC_W-1:0]    out_fraction_numerator,
  output logic [rau_pkg::FRAC_W-1:0]    out_reduced_denominator
);

  localparam int DW = rau_pkg::DW;

  typedef enum logic [6:0] {
    B_IDLE = 7'b0000001,
    B_TWOS = 7'b0000010,
    B_GCD  = 7'b0000100,
    B_DIVN = 7'b0001000,
    B_DIVD = 7'b0010000,
    B_DIVQ = 7'b0100000,
    B_OUT  = 7'b1000000
  } back_state_t;

  back_state_t state_r, state_nxt;
  logic [DW-1:0] a_r, a_nxt, b_r, b_nxt, num_r, num_nxt, den_r, den_nxt;
  logic [DW-1:0] quo_r, quo_nxt, rem_r, rem_nxt, dv_r, dv_nxt;
  logic [rau_pkg::SHIFT_W-1:0] k_r, k_nxt;
  logic [rau_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic neg_r, neg_nxt, inf_r, inf_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_inf_r, out_neg_r;
  logic [rau_pkg::WHOLE_W-1:0] out_whole_r;
  logic [rau_pkg::FRAC_W-1:0]  out_frac_r, out_den_r;
  logic [DW:0] t, diff;
  logic ge;
  logic [DW-1:0] rem_step, quo_step;
  logic last;
  logic load_out;

  assign t = {rem_r, quo_r[DW-1]};
  assign diff = t - {1'b0, dv_r};
  assign ge = (t >= {1'b0, dv_r});
  assign rem_step = ge ? diff[DW-1:0] : t[DW-1:0];
  assign quo_step = {quo_r[DW-2:0], ge};
  assign last = (cnt_r == '1);

  assign q_pop = (state_r == B_IDLE) && !q_empty;
  assign load_out = (state_r == B_OUT) && (!out_valid_r || pop);

  always_comb begin
    state_nxt = state_r;
    a_nxt = a_r; b_nxt = b_r; num_nxt = num_r; den_nxt = den_r;
    quo_nxt = quo_r; rem_nxt = rem_r; dv_nxt = dv_r;
    k_nxt = k_r; cnt_nxt = cnt_r; neg_nxt = neg_r; inf_nxt = inf_r;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          a_nxt = q_item.num_mag;
          b_nxt = q_item.den_mag;
          num_nxt = q_item.num_mag;
          den_nxt = q_item.den_mag;
          neg_nxt = q_item.num_neg ^ q_item.den_neg;
          k_nxt = '0;
          inf_nxt = 1'b0;
          quo_nxt = '0;
          rem_nxt = '0;
          if (q_item.den_mag == '0) begin
            inf_nxt = 1'b1;
            neg_nxt = 1'b0;
            den_nxt = '0;
            state_nxt = B_OUT;
          end else if (q_item.num_mag == '0) begin
            neg_nxt = 1'b0;
            den_nxt = DW'(1);
            state_nxt = B_OUT;
          end else begin
            state_nxt = B_TWOS;
          end
        end
      end
      B_TWOS: begin
        if (!a_r[0] && !b_r[0]) begin
          a_nxt = a_r >> 1;
          b_nxt = b_r >> 1;
          k_nxt = k_r + 1'b1;
        end else begin
          state_nxt = B_GCD;
        end
      end
      B_GCD: begin
        if (a_r == b_r) begin
          dv_nxt = a_r << k_r;
          quo_nxt = num_r;
          rem_nxt = '0;
          cnt_nxt = '0;
          state_nxt = B_DIVN;
        end else if (!a_r[0]) begin
          a_nxt = a_r >> 1;
        end else if (!b_r[0]) begin
          b_nxt = b_r >> 1;
        end else if (a_r > b_r) begin
          a_nxt = (a_r - b_r) >> 1;
        end else begin
          b_nxt = (b_r - a_r) >> 1;
        end
      end
      B_DIVN: begin
        quo_nxt = quo_step;
        rem_nxt = rem_step;
        cnt_nxt = cnt_r + 1'b1;
        if (last) begin
          num_nxt = quo_step;
          quo_nxt = den_r;
          rem_nxt = '0;
          state_nxt = B_DIVD;
        end
      end
      B_DIVD: begin
        quo_nxt = quo_step;
        rem_nxt = rem_step;
        cnt_nxt = cnt_r + 1'b1;
        if (last) begin
          den_nxt = quo_step;
          dv_nxt = quo_step;
          quo_nxt = num_r;
          rem_nxt = '0;
          state_nxt = B_DIVQ;
        end
      end
      B_DIVQ: begin
        quo_nxt = quo_step;
        rem_nxt = rem_step;
        cnt_nxt = cnt_r + 1'b1;
        if (last) state_nxt = B_OUT;
      end
      B_OUT: begin
        if (load_out) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop && out_valid_r) out_valid_nxt = 1'b0;
    if (load_out) out_valid_nxt = 1'b1;
  end

  assign empty = !out_valid_r;
  assign out_is_infinite = out_inf_r;
  assign out_is_negative = out_neg_r;
  assign out_whole_part = out_whole_r;
  assign out_fraction_numerator = out_frac_r;
  assign out_reduced_denominator = out_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt; b_r <= b_nxt; num_r <= num_nxt; den_r <= den_nxt;
    quo_r <= quo_nxt; rem_r <= rem_nxt; dv_r <= dv_nxt;
    k_r <= k_nxt; cnt_r <= cnt_nxt; neg_r <= neg_nxt; inf_r <= inf_nxt;
    if (load_out) begin
      out_inf_r <= inf_r;
      out_neg_r <= neg_r;
      out_whole_r <= rau_pkg::WHOLE_W'(quo_r);
      out_frac_r <= rem_r[rau_pkg::FRAC_W-1:0];
      out_den_r <= den_r[rau_pkg::FRAC_W-1:0];
    end
  end

endmodule

### hw/rtl/rational_arithmetic_unit.sv
// Rational arithmetic unit: combines two signed fractions, or reduces the first
// one, and gives reduced sign, whole part, remainder numerator and denominator.
// Input channel: drive operands with push; a word is taken when push is high
// and full is low. Result channel: a result waits on the out_ ports while
// empty is low and is taken when pop is high.
// Front: one 32x32 multiplier shared by states F_MUL0 to F_MUL2, then an add;
// reduce-only words skip these, and full stays high until the item is queued.
// Back: binary GCD (one shift or subtract per cycle), then three restoring
// divisions on one shared divider.
// Infinite and zero results skip the GCD and divisions. The back works on
// one item at a time, so the divider and GCD loop bound the throughput.
// A 2-word queue sits between front and back, and a result register at
// the output, so the front takes new words while a result waits.
// When the receiver stalls the back holds its finished result and the
// queue fills, after which full stays high.
// Reset (rst_n low, synchronous) empties queue and output; no state is
// kept between words.
module rational_arithmetic_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  logic [2:0]                      in_opcode,
  input  logic signed [rau_pkg::IN_W-1:0] in_first_numerator,
  input  logic signed [rau_pkg::IN_W-1:0] in_first_denominator,
  input  logic signed [rau_pkg::IN_W-1:0] in_second_numerator,
  input  logic signed [rau_pkg::IN_W-1:0] in_second_denominator,
  output logic                            empty,
  input  logic                            pop,
  output logic                            out_is_infinite,
  output logic                            out_is_negative,
  output logic [rau_pkg::WHOLE_W-1:0]     out_whole_part,
  output logic [rau_pkg::FRAC_W-1:0]      out_fraction_numerator,
  output logic [rau_pkg::FRAC_W-1:0]      out_reduced_denominator
);

  rau_pkg::rau_item_t wr_item, rd_item;
  logic q_push, q_full, q_pop, q_empty;

  rau_front u_front (
    .clk, .rst_n, .push, .full, .in_opcode,
    .in_first_numerator, .in_first_denominator,
    .in_second_numerator, .in_second_denominator,
    .q_push, .q_full, .q_item(wr_item)
  );

  rau_fifo u_fifo (
    .clk, .rst_n,
    .wr_en(q_push), .wr_data(wr_item), .fifo_full(q_full),
    .rd_en(q_pop), .rd_data(rd_item), .fifo_empty(q_empty)
  );

  rau_back u_back (
    .clk, .rst_n, .q_empty, .q_item(rd_item), .q_pop,
    .empty, .pop, .out_is_infinite, .out_is_negative, .out_whole_part,
    .out_fraction_numerator, .out_reduced_denominator
  );

endmodule

### hw/rtl/rau_checker.sv
module rau_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        push,
  input logic                        full,
  input logic                        empty,
  input logic                        pop,
  input logic                        out_is_infinite,
  input logic                        out_is_negative,
  input logic [rau_pkg::WHOLE_W-1:0] out_whole_part,
  input logic [rau_pkg::FRAC_W-1:0]  out_fraction_numerator,
  input logic [rau_pkg::FRAC_W-1:0]  out_reduced_denominator
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("output not empty after reset");

  a_busy_after_push: assert property (@(posedge clk) disable iff (!rst_n)
    push && !full |=> full)
    else $error("front took a word without going busy");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_whole_part) &&
      $stable(out_reduced_denominator))
    else $error("stalled result changed");

  a_inf_fields: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_is_infinite |-> !out_is_negative && out_whole_part == '0 &&
      out_fraction_numerator == '0 && out_reduced_denominator == '0)
    else $error("infinite result carries nonzero fields");

  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !out_is_infinite |-> out_reduced_denominator != '0 &&
      out_fraction_numerator < out_reduced_denominator)
    else $error("finite result not a proper fraction");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
  .clk, .rst_n, .push, .full, .empty, .pop, .out_is_infinite, .out_is_negative,
  .out_whole_part, .out_fraction_numerator, .out_reduced_denominator
);

### tb/sv/rational_arithmetic_unit_tb.sv
`timescale 1ns / 1ps

module rational_arithmetic_unit_tb;

  typedef struct {
    logic          neg;
    logic [63:0]   mag;
  } smag_t;

  typedef struct {
    logic                        inf;
    logic                        neg;
    logic [rau_pkg::WHOLE_W-1:0] whole;
    logic [rau_pkg::FRAC_W-1:0]  frac;
    logic [rau_pkg::FRAC_W-1:0]  den;
  } rat_res_t;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] n1, d1, n2, d2;
    bit          typed;
    rat_res_t    res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic [2:0] in_opcode = '0;
  logic signed [rau_pkg::IN_W-1:0] in_first_numerator = '0;
  logic signed [rau_pkg::IN_W-1:0] in_first_denominator = '0;
  logic signed [rau_pkg::IN_W-1:0] in_second_numerator = '0;
  logic signed [rau_pkg::IN_W-1:0] in_second_denominator = '0;
  logic full, empty;
  logic out_is_infinite, out_is_negative;
  logic [rau_pkg::WHOLE_W-1:0] out_whole_part;
  logic [rau_pkg::FRAC_W-1:0] out_fraction_numerator, out_reduced_denominator;

  rat_res_t pending_q[$];
  stim_row_t rows[$];
  int errors = 0;
  int phase = 0;
  int cycles = 0;

  rational_arithmetic_unit DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic smag_t to_mag(logic [31:0] v);
    smag_t r;
    r.neg = v[31];
    r.mag = v[31] ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
    return r;
  endfunction

  function automatic smag_t mag_mul(smag_t x, smag_t y);
    smag_t r;
    r.mag = x.mag * y.mag;
    r.neg = (r.mag != 0) && (x.neg != y.neg);
    return r;
  endfunction

  function automatic smag_t mag_add(smag_t x, smag_t y);
    smag_t r;
    if (x.neg == y.neg) begin
      r.mag = x.mag + y.mag;
      r.neg = x.neg;
    end else if (x.mag >= y.mag) begin
      r.mag = x.mag - y.mag;
      r.neg = x.neg;
    end else begin
      r.mag = y.mag - x.mag;
      r.neg = y.neg;
    end
    if (r.mag == 0) r.neg = 1'b0;
    return r;
  endfunction

  function automatic rat_res_t reduce_fraction(logic [2:0] op, logic [31:0] a, b, c, d);
    smag_t n1, d1, n2, d2, num, den, t;
    logic [63:0] g, x, y, tmp, n, dd;
    rat_res_t r;
    n1 = to_mag(a);
    d1 = to_mag(b);
    n2 = to_mag(c);
    d2 = to_mag(d);
    case (op)
      rau_pkg::OP_ADD: begin
        den = mag_mul(d1, d2);
        num = mag_add(mag_mul(n1, d2), mag_mul(n2, d1));
      end
      rau_pkg::OP_SUB: begin
        t = mag_mul(n2, d1);
        if (t.mag != 0) t.neg = !t.neg;
        den = mag_mul(d1, d2);
        num = mag_add(mag_mul(n1, d2), t);
      end
      rau_pkg::OP_MUL: begin
        den = mag_mul(d1, d2);
        num = mag_mul(n1, n2);
      end
      rau_pkg::OP_DIV: begin
        num = mag_mul(n1, d2);
        den = mag_mul(n2, d1);
      end
      default: begin
        num = n1;
        den = d1;
      end
    endcase
    r = '{1'b0, 1'b0, '0, '0, '0};
    if (den.mag == 0) begin
      r.inf = 1'b1;
    end else if (num.mag == 0) begin
      r.den = 1;
    end else begin
      x = num.mag;
      y = den.mag;
      while (y != 0) begin
        tmp = x % y;
        x = y;
        y = tmp;
      end
      g = x;
      n = num.mag / g;
      dd = den.mag / g;
      r.neg = num.neg != den.neg;
      r.whole = n / dd;
      r.frac = n % dd;
      r.den = dd;
    end
    return r;
  endfunction

  task automatic add_row(logic [2:0] op, logic [31:0] a, b, c, d, bit typed,
                         logic inf = 0, logic neg = 0, logic [63:0] whole = 0,
                         logic [62:0] frac = 0, logic [62:0] den = 0);
    stim_row_t s;
    s.op = op; s.n1 = a; s.d1 = b; s.n2 = c; s.d2 = d;
    s.typed = typed;
    if (typed) s.res = rat_res_t'{inf, neg, whole, frac, den};
    else s.res = reduce_fraction(op, a, b, c, d);
    rows.push_back(s);
  endtask

  function automatic logic [31:0] rand_operand();
    int k;
    k = $urandom_range(0, 9);
    if (k < 4) return $urandom_range(0, 40) - 20;
    if (k == 4) return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'd0};
    if (k == 5) return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0001;
    if (k == 6) return $urandom_range(0, 65535) - 32768;
    return $urandom;
  endfunction

  function automatic int pct_send();
    return (phase == 1) ? 59 : (phase == 3) ? 29 : 0;
  endfunction

  function automatic int pct_recv();
    return (phase == 2) ? 59 : (phase == 3) ? 29 : 0;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    rat_res_t e;
    if (rst_n) begin
      if (pop && !empty) begin
        if (pending_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result word");
        end else begin
          e = pending_q.pop_front();
          if (out_is_infinite !== e.inf || out_is_negative !== e.neg ||
              out_whole_part !== e.whole || out_fraction_numerator !== e.frac ||
              out_reduced_denominator !== e.den) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp inf=%0d neg=%0d whole=%0d frac=%0d den=%0d got inf=%0d neg=%0d whole=%0d frac=%0d den=%0d",
                       e.inf, e.neg, e.whole, e.frac, e.den, out_is_infinite,
                       out_is_negative, out_whole_part, out_fraction_numerator,
                       out_reduced_denominator);
          end
        end
      end
      pop <= ($urandom_range(0, 99) >= pct_recv());
    end
  end

  initial begin
    int total;
    add_row(rau_pkg::OP_RED, 6, 4, 0, 1, 1, 0, 0, 1, 1, 2);
    add_row(rau_pkg::OP_RED, -6, 4, 0, 1, 1, 0, 1, 1, 1, 2);
    add_row(rau_pkg::OP_RED, 0, 5, 0, 1, 1, 0, 0, 0, 0, 1);
    add_row(rau_pkg::OP_RED, 3, 0, 0, 1, 1, 1, 0, 0, 0, 0);
    add_row(rau_pkg::OP_RED, 0, 0, 0, 0, 1, 1, 0, 0, 0, 0);
    add_row(3'd5, 7, 7, 1, 2, 1, 0, 0, 1, 0, 1);
    add_row(3'd6, 9, -3, 1, 2, 1, 0, 1, 3, 0, 1);
    add_row(3'd7, -1, -2, 5, 5, 1, 0, 0, 0, 1, 2);
    add_row(rau_pkg::OP_DIV, 1, 2, 0, 3, 1, 1, 0, 0, 0, 0);
    add_row(rau_pkg::OP_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1, 1, 0, 0,
            64'h4000_0000_0000_0000, 0, 1);
    add_row(rau_pkg::OP_RED, 32'h8000_0000, -1, 0, 1, 1, 0, 0, 64'h8000_0000, 0, 1);
    add_row(rau_pkg::OP_RED, 32'h8000_0000, 1, 0, 1, 1, 0, 1, 64'h8000_0000, 0, 1);
    add_row(rau_pkg::OP_RED, 1, 32'h8000_0000, 0, 1, 1, 0, 1, 0, 1, 63'h8000_0000);
    add_row(rau_pkg::OP_ADD, 1, 2, 1, 3, 0);
    add_row(rau_pkg::OP_SUB, 1, 2, 1, 3, 0);
    add_row(rau_pkg::OP_SUB, 5, 7, 5, 7, 0);
    add_row(rau_pkg::OP_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h8000_0000, 0);
    add_row(rau_pkg::OP_SUB, 32'h8000_0000, 1, 32'h7fff_ffff, 32'h8000_0000, 0);
    add_row(rau_pkg::OP_MUL, 32'h7fff_ffff, 3, 32'h7fff_ffff, 32'h7fff_fffe, 0);
    add_row(rau_pkg::OP_DIV, 32'h7fff_ffff, -7, 32'h8000_0000, 32'h7fff_ffff, 0);
    add_row(rau_pkg::OP_ADD, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1, 0);
    add_row(rau_pkg::OP_DIV, -22, 7, 3, -5, 0);
    for (int i = 0; i < 850; i++)
      add_row(3'($urandom_range(0, 7)), rand_operand(), rand_operand(),
              rand_operand(), rand_operand(), 0);
    total = rows.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < total; i++) begin
      phase = (i < 22) ? 0 : ((i - 22) * 4) / (total - 22);
      while ($urandom_range(0, 99) < pct_send()) begin
        push <= 1'b0;
        @(posedge clk);
      end
      push <= 1'b1;
      in_opcode <= rows[i].op;
      in_first_numerator <= rows[i].n1;
      in_first_denominator <= rows[i].d1;
      in_second_numerator <= rows[i].n2;
      in_second_denominator <= rows[i].d2;
      do @(posedge clk); while (full);
      pending_q.push_back(rows[i].res);
    end
    push <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

### rational_arithmetic_unit.f
hw/rtl/rau_pkg.sv
hw/rtl/rau_front.sv
hw/rtl/rau_fifo.sv
hw/rtl/rau_back.sv
hw/rtl/rational_arithmetic_unit.sv
hw/rtl/rau_checker.sv
tb/sv/rational_arithmetic_unit_tb.sv
